### design/path_entropy_weight_adjust_defines.svh
// Assertion helpers for the path entropy weight adjuster.
`ifndef PATH_ENTROPY_WEIGHT_ADJUST_DEFINES_SVH
`define PATH_ENTROPY_WEIGHT_ADJUST_DEFINES_SVH

// Checked only while out of reset.
`define PEWA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PEWA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/pewa_pkg.sv
package pewa_pkg;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int LN_ITERS = 24;

    localparam logic [15:0] THRESH_RST = 16'd8192;
    localparam logic [15:0] SHRINK_RST = 16'd14746;
    localparam logic [15:0] GROW_RST   = 16'd18022;

    localparam logic [7:0] REG_THRESH = 8'd0;
    localparam logic [7:0] REG_SHRINK = 8'd1;
    localparam logic [7:0] REG_GROW   = 8'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_SEEN_RD,
        ST_CNT_RD,
        ST_CLN_GO,
        ST_CLN_RUN,
        ST_CLN_MUL,
        ST_TERM,
        ST_ACC,
        ST_NLN_GO,
        ST_NLN_RUN,
        ST_NLN_MUL,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_FIN,
        ST_WMUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic upd;
        logic seen_rd;
        logic cnt_rd;
        logic ln_go_c;
        logic ln_go_n;
        logic ln_run;
        logic ln_mul;
        logic term;
        logic acc;
        logic div_go;
        logic div_run;
        logic fin;
        logic wmul;
        logic out_load;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic clr_last;
        logic ln_last;
        logic idx_last;
        logic div_last;
        logic out_busy;
    } status_t;

endpackage

### design/path_entropy_weight_adjust.sv
// Path entropy weight adjuster.
// Slave stream: one node id per transfer, tdata = {path_weight, node_id},
// tlast marks the final node of a path. Only the last transfer's path_weight
// is used.
// Master stream: one result per path, tdata = {new_weight, entropy},
// tuser = {too_long, congested}.
// Config channel: cfg_index 0 threshold, 1 shrink, 2 grow; always ready,
// other indexes are ignored. Write only while idle.
// Node ids: each count is read, then written back in an update step, before
// the next id is taken. Path end: after the last id's update, each distinct
// id gets a seen read, count read, iterative ln, multiplies and an accumulate;
// then ln(n), a bit-serial divide, rounding and a weight multiply fill the
// output register. Reset: the count memory is swept, one bin per cycle, over
// all 2^NODE_ID_BITS bins with s_tready low. A stalled receiver holds the
// result in the output register; nodes of the next path keep being taken, and
// the next path end waits for the register to free up with s_tready low.
module path_entropy_weight_adjust #(
    parameter int NODE_ID_BITS = 8,
    parameter int MAX_PATH_LEN = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [((NODE_ID_BITS + 32 + 7) / 8) * 8 - 1:0] s_tdata, // node_id, path_weight
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [47:0] m_tdata, // entropy, new_weight
    output logic [1:0]  m_tuser, // congested, too_long
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pewa_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic [15:0] ent;
    logic [31:0] wgt;
    logic cong, tlong;

    pewa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    pewa_datapath #(
        .NODE_ID_BITS (NODE_ID_BITS),
        .MAX_PATH_LEN (MAX_PATH_LEN)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_tvalid      (s_tvalid),
        .in_id         (s_tdata[NODE_ID_BITS-1:0]),
        .in_weight     (s_tdata[NODE_ID_BITS+31:NODE_ID_BITS]),
        .in_last       (s_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .out_entropy   (ent),
        .out_weight    (wgt),
        .out_congested (cong),
        .out_too_long  (tlong)
    );

    assign s_tready  = cmd.in_ready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {wgt, ent};
    assign m_tuser   = {tlong, cong};

endmodule

### design/pewa_ctrl.sv
`include "path_entropy_weight_adjust_defines.svh"

module pewa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  pewa_pkg::status_t sts,
    output pewa_pkg::cmd_t   cmd
);
    import pewa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (sts.in_fire) state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd = 1'b1;
                state_next = sts.in_last ? ST_SEEN_RD : ST_IDLE;
            end
            ST_SEEN_RD: begin
                cmd.seen_rd = 1'b1;
                state_next = ST_CNT_RD;
            end
            ST_CNT_RD: begin
                cmd.cnt_rd = 1'b1;
                state_next = ST_CLN_GO;
            end
            ST_CLN_GO: begin
                cmd.ln_go_c = 1'b1;
                state_next = ST_CLN_RUN;
            end
            ST_CLN_RUN: begin
                cmd.ln_run = 1'b1;
                if (sts.ln_last) state_next = ST_CLN_MUL;
            end
            ST_CLN_MUL: begin
                cmd.ln_mul = 1'b1;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                cmd.term = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                state_next = sts.idx_last ? ST_NLN_GO : ST_SEEN_RD;
            end
            ST_NLN_GO: begin
                cmd.ln_go_n = 1'b1;
                state_next = ST_NLN_RUN;
            end
            ST_NLN_RUN: begin
                cmd.ln_run = 1'b1;
                if (sts.ln_last) state_next = ST_NLN_MUL;
            end
            ST_NLN_MUL: begin
                cmd.ln_mul = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_go = 1'b1;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd.div_run = 1'b1;
                if (sts.div_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                state_next = ST_WMUL;
            end
            ST_WMUL: begin
                cmd.wmul = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    `PEWA_ASSERT(ACCEPT_TO_UPD, sts.in_fire |=> state_reg == ST_UPD, "accept not followed by update")
    `PEWA_ASSERT(LOAD_WHEN_FREE, cmd.out_load |-> !sts.out_busy, "result overwrote pending output")
    `PEWA_ASSERT_ALWAYS(RESET_CLEARS, !aresetn |=> state_reg == ST_CLEAR, "reset skipped clear sweep")

endmodule

### design/pewa_datapath.sv
module pewa_datapath #(
    parameter int NODE_ID_BITS = 8,
    parameter int MAX_PATH_LEN = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pewa_pkg::cmd_t          cmd,
    output pewa_pkg::status_t       sts,
    input  logic                    s_tvalid,
    input  logic [NODE_ID_BITS-1:0] in_id,
    input  logic [31:0]             in_weight,
    input  logic                    in_last,
    input  logic                    cfg_valid,
    input  logic [7:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    m_tready,
    output logic                    out_valid,
    output logic [15:0]             out_entropy,
    output logic [31:0]             out_weight,
    output logic                    out_congested,
    output logic                    out_too_long
);
    import pewa_pkg::*;

    localparam int IDW  = NODE_ID_BITS;
    localparam int BINS = 1 << IDW;
    localparam int CW   = $clog2(MAX_PATH_LEN + 1);
    localparam int PW   = $clog2(MAX_PATH_LEN);
    localparam int SW   = CW + 29;
    localparam int LCW  = $clog2(LN_ITERS + 1);
    localparam int DCW  = $clog2(SW + 1);
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_PATH_LEN);

    logic [CW-1:0]  cnt_mem [BINS];
    logic [IDW-1:0] seen_mem [MAX_PATH_LEN];

    logic [15:0] thresh_reg, shrink_reg, grow_reg;
    logic [IDW-1:0] id_reg, seen_q_reg, clr_idx_reg;
    logic [31:0] weight_reg;
    logic last_reg, count_en_reg, overflow_reg;
    logic [CW-1:0] cnt_q_reg, item_cnt_reg, distinct_reg, c_reg;
    logic [PW-1:0] idx_reg;

    logic [31:0] ln_m_reg;
    logic [23:0] ln_frac_reg;
    logic [7:0]  ln_k_reg;
    logic        ln_zero_reg;
    logic [LCW-1:0] ln_cnt_reg;
    logic [31:0] ln_res_reg;
    logic [CW+31:0] term_reg;
    logic [SW-1:0] sum_reg, dvd_reg;
    logic [CW-1:0] rem_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [15:0] ent_reg;
    logic cong_reg;
    logic [33:0] prod_reg;

    logic [CW-1:0] ln_src;
    logic [7:0] ln_k;
    logic [31:0] ln_m0;
    logic [63:0] sq;
    logic [63:0] fix_prod;
    logic [CW:0] r2;
    logic [SW-1:0] ln_wide;
    logic [31:0] ent_q24;
    logic [32:0] ent_rnd;
    logic [47:0] wprod;

    assign sts.in_fire  = s_tvalid & cmd.in_ready;
    assign sts.in_last  = last_reg;
    assign sts.clr_last = (clr_idx_reg == IDW'(BINS - 1));
    assign sts.ln_last  = (ln_cnt_reg == LCW'(1));
    assign sts.idx_last = ({1'b0, idx_reg} == (PW + 1)'(distinct_reg - CW'(1)));
    assign sts.div_last = (div_cnt_reg == DCW'(1));
    assign sts.out_busy = out_valid & ~m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RST;
            shrink_reg <= SHRINK_RST;
            grow_reg   <= GROW_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESH: thresh_reg <= cfg_data;
                REG_SHRINK: shrink_reg <= cfg_data;
                REG_GROW:   grow_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) cnt_mem[clr_idx_reg] <= '0;
        else if (cmd.upd && count_en_reg) cnt_mem[id_reg] <= cnt_q_reg + CW'(1);
        else if (cmd.ln_go_c) cnt_mem[seen_q_reg] <= '0;
        if (sts.in_fire) cnt_q_reg <= cnt_mem[in_id];
        else if (cmd.cnt_rd) cnt_q_reg <= cnt_mem[seen_q_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd && count_en_reg && cnt_q_reg == '0 && distinct_reg < MAX_LEN)
            seen_mem[distinct_reg[PW-1:0]] <= id_reg;
        if (cmd.seen_rd) seen_q_reg <= seen_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            item_cnt_reg <= '0;
            distinct_reg <= '0;
            overflow_reg <= 1'b0;
            idx_reg      <= '0;
            last_reg     <= 1'b0;
            count_en_reg <= 1'b0;
            ln_cnt_reg   <= '0;
            div_cnt_reg  <= '0;
            sum_reg      <= '0;
            out_valid    <= 1'b0;
        end else begin
            if (cmd.clr_step) clr_idx_reg <= clr_idx_reg + IDW'(1);
            if (sts.in_fire) begin
                last_reg     <= in_last;
                count_en_reg <= (item_cnt_reg < MAX_LEN);
            end
            if (cmd.upd) begin
                if (count_en_reg) begin
                    item_cnt_reg <= item_cnt_reg + CW'(1);
                    if (cnt_q_reg == '0 && distinct_reg < MAX_LEN)
                        distinct_reg <= distinct_reg + CW'(1);
                end else begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.ln_go_c || cmd.ln_go_n) ln_cnt_reg <= LCW'(LN_ITERS);
            else if (cmd.ln_run) ln_cnt_reg <= ln_cnt_reg - LCW'(1);
            if (cmd.acc) begin
                sum_reg <= sum_reg + SW'(term_reg);
                idx_reg <= idx_reg + PW'(1);
            end
            if (cmd.div_go) div_cnt_reg <= DCW'(SW);
            else if (cmd.div_run) div_cnt_reg <= div_cnt_reg - DCW'(1);
            if (cmd.out_load) begin
                out_valid    <= 1'b1;
                item_cnt_reg <= '0;
                distinct_reg <= '0;
                overflow_reg <= 1'b0;
                idx_reg      <= '0;
                sum_reg      <= '0;
            end else if (m_tready) begin
                out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        ln_src = cmd.ln_go_n ? item_cnt_reg : cnt_q_reg;
        ln_k = '0;
        for (int b = 0; b < CW; b++) begin
            if (ln_src[b]) ln_k = 8'(b);
        end
        ln_m0 = 32'(ln_src) << (6'd30 - ln_k[5:0]);
        sq = (64'(ln_m_reg) * 64'(ln_m_reg)) >> 30;
        fix_prod = 64'({ln_k_reg, ln_frac_reg}) * 64'(LN2_Q32);
        r2 = {rem_reg, dvd_reg[SW-1]};
        ln_wide = SW'(ln_res_reg);
        ent_q24 = (dvd_reg >= ln_wide) ? 32'd0 : ln_res_reg - dvd_reg[31:0];
        ent_rnd = (33'(ent_q24) + 33'd1024) >> 11;
        wprod = 48'(weight_reg) * 48'(cong_reg ? shrink_reg : grow_reg);
    end

    always_ff @(posedge aclk) begin
        if (sts.in_fire) begin
            id_reg     <= in_id;
            weight_reg <= in_weight;
        end
        if (cmd.ln_go_c) c_reg <= cnt_q_reg;
        if (cmd.ln_go_c || cmd.ln_go_n) begin
            ln_m_reg    <= ln_m0;
            ln_k_reg    <= ln_k;
            ln_frac_reg <= '0;
            ln_zero_reg <= (ln_src == '0);
        end else if (cmd.ln_run) begin
            if (sq[31]) begin
                ln_m_reg    <= sq[32:1];
                ln_frac_reg <= {ln_frac_reg[22:0], 1'b1};
            end else begin
                ln_m_reg    <= sq[31:0];
                ln_frac_reg <= {ln_frac_reg[22:0], 1'b0};
            end
        end
        if (cmd.ln_mul) ln_res_reg <= ln_zero_reg ? 32'd0 : fix_prod[63:32];
        if (cmd.term) term_reg <= (CW + 32)'(c_reg) * (CW + 32)'(ln_res_reg);
        if (cmd.div_go) begin
            dvd_reg <= sum_reg;
            rem_reg <= '0;
        end else if (cmd.div_run) begin
            if (r2 >= {1'b0, item_cnt_reg}) begin
                rem_reg <= CW'(r2 - {1'b0, item_cnt_reg});
                dvd_reg <= {dvd_reg[SW-2:0], 1'b1};
            end else begin
                rem_reg <= r2[CW-1:0];
                dvd_reg <= {dvd_reg[SW-2:0], 1'b0};
            end
        end
        if (cmd.fin) begin
            ent_reg  <= (ent_rnd > 33'hFFFF) ? 16'hFFFF : ent_rnd[15:0];
            cong_reg <= ((ent_rnd > 33'hFFFF) ? 16'hFFFF : ent_rnd[15:0]) > thresh_reg;
        end
        if (cmd.wmul) prod_reg <= wprod[47:14];
        if (cmd.out_load) begin
            out_entropy   <= ent_reg;
            out_weight    <= (prod_reg > 34'hFFFFFFFF) ? 32'hFFFFFFFF : prod_reg[31:0];
            out_congested <= cong_reg;
            out_too_long  <= overflow_reg;
        end
    end

endmodule

### verif/tb_path_entropy_weight_adjust.sv
`timescale 1ns / 100ps

module tb_path_entropy_weight_adjust;
    import pewa_pkg::*;

    localparam int ID_BINS = 256;
    localparam int PATH_LIMIT = 256;
    localparam int STALL_LIMIT = 60000;
    localparam logic [7:0] REG_UNUSED = 8'hFF;

    typedef struct packed {
        logic [15:0] entropy;
        logic [31:0] new_weight;
        logic        congested;
        logic        too_long;
    } path_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    path_entropy_weight_adjust dut (.*);

    always #2 aclk = ~aclk;

    // predictor state
    logic [15:0] thresh_q13;
    logic [15:0] shrink_q14;
    logic [15:0] grow_q14;
    logic [8:0]  bin_count [ID_BINS];
    int          node_total;
    logic        path_overflow;

    path_result_t path_results [$];
    int  err_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  nodes_sent = 0;
    int  stall_cycles = 0;

    function automatic logic [63:0] ln_q24(input logic [31:0] c);
        logic [63:0] m;
        logic [63:0] frac;
        int k;
        frac = 0;
        k = 0;
        if (c == 0)
            return 0;
        while (k < 31 && (c >> (k + 1)) != 0)
            k++;
        m = 64'(c) << (30 - k);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (((64'(k) << 24) | frac) * 64'(LN2_Q32)) >> 32;
    endfunction

    function automatic void predict_node(input logic [7:0] id, input logic [31:0] weight,
                                         input logic last);
        logic [63:0] sum;
        logic [63:0] ent;
        logic [63:0] q;
        logic [63:0] prod;
        logic [15:0] factor;
        path_result_t res;
        sum = 0;
        if (node_total < PATH_LIMIT) begin
            bin_count[id]++;
            node_total++;
        end else begin
            path_overflow = 1'b1;
        end
        if (!last)
            return;
        for (int i = 0; i < ID_BINS; i++)
            if (bin_count[i] != 0)
                sum += 64'(bin_count[i]) * ln_q24(32'(bin_count[i]));
        ent = ln_q24(32'(node_total));
        if (node_total != 0) begin
            q = sum / node_total;
            ent = (q >= ent) ? 64'd0 : ent - q;
        end else begin
            ent = 0;
        end
        ent = (ent + 64'd1024) >> 11;
        if (ent > 64'hFFFF)
            ent = 64'hFFFF;
        res.entropy = ent[15:0];
        res.congested = res.entropy > thresh_q13;
        factor = res.congested ? shrink_q14 : grow_q14;
        prod = (64'(weight) * 64'(factor)) >> 14;
        res.new_weight = (prod > 64'hFFFFFFFF) ? 32'hFFFFFFFF : prod[31:0];
        res.too_long = path_overflow;
        path_results.insert(path_results.size(), res);
        for (int i = 0; i < ID_BINS; i++)
            bin_count[i] = '0;
        node_total = 0;
        path_overflow = 1'b0;
    endfunction

    task automatic send_node(input logic [7:0] id, input logic [31:0] weight, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = {weight, id};
        s_tlast = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_node(id, weight, last);
        nodes_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (path_results.size() != 0)
            @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        wait_idle();
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_THRESH: thresh_q13 = val;
            REG_SHRINK: shrink_q14 = val;
            REG_GROW:   grow_q14 = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_path(input int len, input int alphabet, input logic [31:0] weight);
        logic [7:0] base;
        base = 8'($urandom);
        for (int i = 0; i < len; i++)
            send_node(base + 8'($urandom_range(0, alphabet - 1)),
                      (i == len - 1) ? weight : $urandom, i == len - 1);
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'hFFFFFFFF;
            1: return 32'h0;
            2: return 32'h00010000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_nodes();
        send_node(8'h00, 32'hFFFFFFFF, 1'b1);
        send_node(8'hFF, 32'h0, 1'b1);
        send_node(8'h00, 32'h0, 1'b0);
        send_node(8'hFF, 32'hFFFFFFFF, 1'b1);
        send_node(8'hAA, 32'h0, 1'b0);
        send_node(8'h55, 32'h0, 1'b0);
        send_node(8'hAA, 32'h0, 1'b0);
        send_node(8'h0F, 32'hA5A5A5A5, 1'b1);
        for (int i = 0; i < 8; i++)
            send_node(8'(i * 37), 32'h5A5A5A5A, i == 7);
        for (int i = 0; i < 4; i++)
            send_node(8'h42, 32'h12345678, i == 3);
    endtask

    task automatic test_config_extremes();
        write_reg(REG_THRESH, 16'h0000);
        write_reg(REG_SHRINK, 16'hFFFF);
        send_path(3, 4, 32'hFFFFFFFF);
        send_path(1, 1, 32'hFFFFFFFF);
        write_reg(REG_THRESH, 16'hFFFF);
        write_reg(REG_GROW, 16'h0000);
        send_path(6, 256, 32'hFFFFFFFF);
        write_reg(REG_GROW, 16'hFFFF);
        send_path(5, 2, 32'hFFFFFFFF);
        write_reg(REG_UNUSED, 16'h1234);
        write_reg(REG_GROW + 8'd1, 16'h4321);
        send_path(4, 4, 32'h80000000);
        write_reg(REG_THRESH, THRESH_RST);
        write_reg(REG_SHRINK, SHRINK_RST);
        write_reg(REG_GROW, GROW_RST);
    endtask

    task automatic test_long_paths();
        // every id distinct, then a path past the length limit ending on a dropped id
        for (int i = 0; i < PATH_LIMIT; i++)
            send_node(8'(i), $urandom, i == PATH_LIMIT - 1);
        send_path(PATH_LIMIT + 5, 16, rand_weight());
        wait_idle();
    endtask

    task automatic test_random_paths(input int node_goal);
        int len;
        int alphabet;
        int stop_at;
        stop_at = nodes_sent + node_goal;
        while (nodes_sent < stop_at) begin
            case ($urandom_range(0, 19))
                0: len = $urandom_range(250, 270);
                1, 2, 3: len = $urandom_range(13, 60);
                default: len = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 4))
                0: alphabet = 1;
                1: alphabet = 2;
                2: alphabet = 4;
                3: alphabet = 16;
                default: alphabet = 256;
            endcase
            send_path(len, alphabet, rand_weight());
            if ($urandom_range(0, 9) == 0)
                wait_idle();
        end
    endtask

    task automatic test_random_config();
        write_reg(REG_THRESH, 16'($urandom_range(4000, 20000)));
        write_reg(REG_SHRINK, 16'($urandom));
        write_reg(REG_GROW, 16'($urandom));
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge aclk) begin
        path_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (path_results.size() == 0) begin
                $error("result transfer with no path pending: tdata %h tuser %b",
                       m_tdata, m_tuser);
                err_count++;
            end else begin
                exp_res = path_results.pop_front();
                if (m_tdata[15:0] !== exp_res.entropy) begin
                    $error("entropy expected %h actual %h", exp_res.entropy, m_tdata[15:0]);
                    err_count++;
                end
                if (m_tdata[47:16] !== exp_res.new_weight) begin
                    $error("new_weight expected %h actual %h",
                           exp_res.new_weight, m_tdata[47:16]);
                    err_count++;
                end
                if (m_tuser[0] !== exp_res.congested) begin
                    $error("congested expected %b actual %b", exp_res.congested, m_tuser[0]);
                    err_count++;
                end
                if (m_tuser[1] !== exp_res.too_long) begin
                    $error("too_long expected %b actual %b", exp_res.too_long, m_tuser[1]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        thresh_q13 = THRESH_RST;
        shrink_q14 = SHRINK_RST;
        grow_q14 = GROW_RST;
        for (int i = 0; i < ID_BINS; i++)
            bin_count[i] = '0;
        node_total = 0;
        path_overflow = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 53;
        test_directed_nodes();
        test_config_extremes();
        test_random_paths(500);

        send_idle_pct = 53;
        recv_idle_pct = 34;
        test_random_config();
        test_random_paths(400);
        test_long_paths();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_THRESH, THRESH_RST);
        write_reg(REG_SHRINK, SHRINK_RST);
        write_reg(REG_GROW, GROW_RST);
        test_random_paths(500);

        while (path_results.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
